/* rtl/pcup_pkg.sv */
package pcup_pkg;

    // Default palette depth.
    localparam int PALETTE_DEPTH_DEF = 256;

    // Request codes.
    localparam logic [2:0] REQ_RAW_UNPACK    = 3'd0;
    localparam logic [2:0] REQ_SCALED_UNPACK = 3'd1;
    localparam logic [2:0] REQ_RAW_PACK      = 3'd2;
    localparam logic [2:0] REQ_SCALED_PACK   = 3'd3;
    localparam logic [2:0] REQ_PAL_WRITE     = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BPP     = 3'd0;
    localparam logic [2:0] CFG_SHIFTS  = 3'd1;
    localparam logic [2:0] CFG_LOSSES  = 3'd2;
    localparam logic [2:0] CFG_CKEY    = 3'd3;
    localparam logic [2:0] CFG_CKEY_EN = 3'd4;

    // Channel positions.
    localparam int CH_ALPHA = 3;

    typedef struct packed {
        logic [2:0]  bpp;
        logic [19:0] shifts;
        logic [15:0] losses;
        logic [31:0] ckey;
        logic        ck_en;
    } cfg_t;

    // Word held in the first pipeline stage.
    typedef struct packed {
        logic [2:0]       req;
        logic [31:0]      pix;
        logic [3:0][7:0]  ch;
        logic [7:0]       pal_idx;
        logic             paletted;
        logic             ck_hit;
    } s1_t;

    // Word held in the second pipeline stage.
    typedef struct packed {
        logic [2:0]       req;
        logic             paletted;
        logic             ck_hit;
        logic             pal_oor;
        logic [3:0][7:0]  raw;
        logic [31:0]      packed_pix;
    } s2_t;

    // Odd pixel sizes behave as four bytes.
    function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
        if (bpp >= 3'd1 && bpp <= 3'd4)
            return bpp;
        return 3'd4;
    endfunction

    function automatic logic [31:0] width_mask(input logic [2:0] bpp);
        logic [31:0] m;
        unique case (eff_bpp(bpp))
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] shift_of(input cfg_t cfg, input int c);
        return cfg.shifts[5*c +: 5];
    endfunction

    function automatic logic [3:0] loss_of(input cfg_t cfg, input int c);
        return cfg.losses[4*c +: 4];
    endfunction

    // Channel mask, (0xFF >> loss) << shift, kept to 32 bits.
    function automatic logic [31:0] mask_of(input cfg_t cfg, input int c);
        logic [31:0] base;
        base = {24'd0, 8'hFF >> loss_of(cfg, c)};
        return base << shift_of(cfg, c);
    endfunction

endpackage

/* rtl/pcup_in_if.sv */
interface pcup_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] pixel_value;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [7:0]  in_alpha;
    logic [7:0]  palette_index;

    modport source (
        output valid, req_type, pixel_value, in_red, in_green, in_blue, in_alpha,
               palette_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, pixel_value, in_red, in_green, in_blue, in_alpha,
               palette_index,
        output ready
    );
endinterface

/* rtl/pcup_out_if.sv */
interface pcup_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;

    modport source (
        output valid, out_pixel, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_pixel, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

/* rtl/pcup_decode.sv */
module pcup_decode (
    input  logic           clk,
    input  logic           rst_n,
    pcup_in_if.sink        src,
    input  pcup_pkg::cfg_t cfg,
    output pcup_pkg::s1_t  s1,
    output logic           s1_valid,
    input  logic           s1_ready
);

    pcup_pkg::s1_t s1_reg;
    pcup_pkg::s1_t s1_next;
    logic          valid_reg;
    logic          take;
    logic [31:0]   alpha_mask;

    // The stage takes a word when it is empty or its word moves on.
    assign take      = !valid_reg || s1_ready;
    assign src.ready = take;

    // Trim the pixel to its size and run the colour key comparison.
    always_comb
    begin
        alpha_mask       = pcup_pkg::mask_of(cfg, pcup_pkg::CH_ALPHA);
        s1_next.req      = src.req_type;
        s1_next.pix      = src.pixel_value & pcup_pkg::width_mask(cfg.bpp);
        s1_next.ch       = {src.in_alpha, src.in_blue, src.in_green, src.in_red};
        s1_next.pal_idx  = src.palette_index;
        s1_next.paletted = (pcup_pkg::eff_bpp(cfg.bpp) == 3'd1);
        s1_next.ck_hit   = cfg.ck_en &&
                           ((cfg.ckey & ~alpha_mask) == (s1_next.pix & ~alpha_mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= src.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && src.valid)
            s1_reg <= s1_next;
    end

    assign s1       = s1_reg;
    assign s1_valid = valid_reg;

endmodule

/* rtl/pcup_extract.sv */
module pcup_extract #(
    parameter int PALETTE_DEPTH = pcup_pkg::PALETTE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pcup_pkg::cfg_t cfg,
    input  pcup_pkg::s1_t  s1,
    input  logic           s1_valid,
    output logic           s1_ready,
    output pcup_pkg::s2_t  s2,
    output logic [23:0]    pal_rgb,
    output logic           s2_valid,
    input  logic           s2_ready
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [23:0]      mem [PALETTE_DEPTH];
    logic [23:0]      rd_reg;
    pcup_pkg::s2_t    s2_reg;
    pcup_pkg::s2_t    s2_next;
    logic             valid_reg;
    logic             take;
    logic             load;
    logic             wr_ok;
    logic [3:0][31:0] shifted;
    logic [3:0][31:0] term;
    logic [7:0]       x;
    logic [31:0]      packed_all;

    assign take     = !valid_reg || s2_ready;
    assign load     = take && s1_valid;
    assign s1_ready = take;
    assign wr_ok    = ({1'b0, s1.pal_idx} < 9'(PALETTE_DEPTH));

    // Raw channel extraction and the packed word, one lane per channel.
    always_comb
    begin
        packed_all = 32'd0;
        for (int c = 0; c < 4; c++)
        begin
            shifted[c] = s1.pix >> pcup_pkg::shift_of(cfg, c);
            x = (s1.req == pcup_pkg::REQ_SCALED_PACK) ?
                (s1.ch[c] >> pcup_pkg::loss_of(cfg, c)) : s1.ch[c];
            term[c] = {24'd0, x} << pcup_pkg::shift_of(cfg, c);
            packed_all = packed_all | term[c];
        end
        s2_next.req      = s1.req;
        s2_next.paletted = s1.paletted;
        s2_next.ck_hit   = s1.ck_hit;
        s2_next.pal_oor  = ({1'b0, s1.pix[7:0]} >= 9'(PALETTE_DEPTH));
        for (int c = 0; c < 4; c++)
            s2_next.raw[c] = shifted[c][7:0] & (8'hFF >> pcup_pkg::loss_of(cfg, c));
        if (s1.req == pcup_pkg::REQ_RAW_PACK || s1.req == pcup_pkg::REQ_SCALED_PACK)
            s2_next.packed_pix = packed_all & pcup_pkg::width_mask(cfg.bpp);
        else
            s2_next.packed_pix = 32'd0;
    end

    // Palette store: written by palette write words, read for every word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (s1.req == pcup_pkg::REQ_PAL_WRITE && wr_ok)
                mem[s1.pal_idx[AW-1:0]] <= {s1.ch[0], s1.ch[1], s1.ch[2]};
            rd_reg <= mem[s1.pix[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s2_reg <= s2_next;
    end

    assign s2       = s2_reg;
    assign pal_rgb  = rd_reg;
    assign s2_valid = valid_reg;

endmodule

/* rtl/pcup_scale.sv */
module pcup_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  pcup_pkg::cfg_t cfg,
    input  pcup_pkg::s2_t  s2,
    input  logic [23:0]    pal_rgb,
    input  logic           s2_valid,
    output logic           s2_ready,
    pcup_out_if.source     dst
);

    logic            valid_reg;
    logic            take;
    logic [31:0]     pix_reg;
    logic [3:0][7:0] ch_reg;
    logic [31:0]     pix_next;
    logic [3:0][7:0] ch_next;
    logic [3:0][7:0] v;
    logic [23:0]     rgb;

    assign take     = !valid_reg || dst.ready;
    assign s2_ready = take;

    // Palette lookup, colour key, loss scaling and result selection.
    always_comb
    begin
        pix_next = 32'd0;
        ch_next  = '0;
        rgb      = s2.pal_oor ? 24'd0 : pal_rgb;
        v        = s2.raw;
        unique case (s2.req)
            pcup_pkg::REQ_RAW_UNPACK,
            pcup_pkg::REQ_SCALED_UNPACK:
            begin
                if (s2.paletted)
                begin
                    ch_next[0] = rgb[23:16];
                    ch_next[1] = rgb[15:8];
                    ch_next[2] = rgb[7:0];
                    ch_next[3] = (s2.req == pcup_pkg::REQ_RAW_UNPACK && s2.ck_hit) ?
                                 8'h00 : 8'hFF;
                end
                else
                begin
                    if (s2.ck_hit)
                        v[3] = 8'h00;
                    if (s2.req == pcup_pkg::REQ_SCALED_UNPACK)
                    begin
                        for (int c = 0; c < 3; c++)
                            ch_next[c] = v[c] << pcup_pkg::loss_of(cfg, c);
                        if (pcup_pkg::loss_of(cfg, pcup_pkg::CH_ALPHA) == 4'd8)
                            ch_next[3] = 8'hFF;
                        else
                            ch_next[3] = v[3] << pcup_pkg::loss_of(cfg, pcup_pkg::CH_ALPHA);
                    end
                    else
                        ch_next = v;
                end
            end
            pcup_pkg::REQ_RAW_PACK,
            pcup_pkg::REQ_SCALED_PACK:
                pix_next = s2.packed_pix;
            default:
            begin
                pix_next = 32'd0;
                ch_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && s2_valid)
        begin
            pix_reg <= pix_next;
            ch_reg  <= ch_next;
        end
    end

    assign dst.valid     = valid_reg;
    assign dst.out_pixel = pix_reg;
    assign dst.out_red   = ch_reg[0];
    assign dst.out_green = ch_reg[1];
    assign dst.out_blue  = ch_reg[2];
    assign dst.out_alpha = ch_reg[3];

endmodule

/* rtl/pixel_channel_unpack_pack.sv */
// Channel   Direction  Handshake      Word
// pix_in    sink       valid/ready    req_type, pixel_value, in_*, palette_index
// pix_out   source     valid/ready    out_pixel, out_red/green/blue/alpha
// cfg       write      cfg_we         cfg_index, cfg_data
//
// Three register stages: decode, extract with palette read, scale into the
// output register. One word per clock while the output side is ready.
// Each stage holds its own valid bit and refills as soon as its word moves on,
// so a stalled output still lets earlier stages fill their bubbles.
// Reset clears the valid bits and loads the register defaults; the palette
// store is not cleared and must be written before it is read.
module pixel_channel_unpack_pack #(
    parameter int PALETTE_DEPTH = pcup_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcup_in_if.sink     pix_in,
    pcup_out_if.source  pix_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pcup_pkg::cfg_t cfg_reg;
    pcup_pkg::s1_t  s1;
    pcup_pkg::s2_t  s2;
    logic           s1_valid;
    logic           s1_ready;
    logic           s2_valid;
    logic           s2_ready;
    logic [23:0]    pal_rgb;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bpp    <= 3'd4;
            cfg_reg.shifts <= 20'd8728;
            cfg_reg.losses <= 16'd0;
            cfg_reg.ckey   <= 32'd0;
            cfg_reg.ck_en  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcup_pkg::CFG_BPP:     cfg_reg.bpp    <= cfg_data[2:0];
                pcup_pkg::CFG_SHIFTS:  cfg_reg.shifts <= cfg_data[19:0];
                pcup_pkg::CFG_LOSSES:  cfg_reg.losses <= cfg_data[15:0];
                pcup_pkg::CFG_CKEY:    cfg_reg.ckey   <= cfg_data;
                pcup_pkg::CFG_CKEY_EN: cfg_reg.ck_en  <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    pcup_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (pix_in),
        .cfg      (cfg_reg),
        .s1       (s1),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready)
    );

    pcup_extract #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_extract (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s1       (s1),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s2       (s2),
        .pal_rgb  (pal_rgb),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready)
    );

    pcup_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s2       (s2),
        .pal_rgb  (pal_rgb),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .dst      (pix_out)
    );

`ifndef SYNTHESIS
    // A colour key hit is only ever flagged with the key test enabled.
    a_ck_hit_en: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s1.ck_hit |-> cfg_reg.ck_en)
        else $error("colour key hit without key enable");

    // Only pack requests carry a packed word down the pipeline.
    a_packed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && s2.req != pcup_pkg::REQ_RAW_PACK &&
        s2.req != pcup_pkg::REQ_SCALED_PACK |-> s2.packed_pix == 32'd0)
        else $error("packed word on a non-pack request");

    // The paletted flag of a word in flight follows the pixel size register.
    a_paletted: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> s2.paletted == (pcup_pkg::eff_bpp(cfg_reg.bpp) == 3'd1))
        else $error("paletted flag out of step with pixel size");
`endif

endmodule

/* verif/testbench.sv */
module testbench;

    // Request codes that the block does not know; they must give an all-zero word.
    localparam logic [2:0] REQ_BAD_LO  = 3'd5;
    localparam logic [2:0] REQ_BAD_MID = 3'd6;
    localparam logic [2:0] REQ_BAD_HI  = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_WORDS   = 50;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int REPORT_CAP      = 200;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] pix;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  idx;
    } pix_req_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } pix_res_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        pix_req_t    word;
        bit          fixed;
        pix_res_t    res;
    } stim_row_t;

    typedef struct {
        bit       fixed;
        pix_res_t res;
    } known_answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    pcup_in_if  pix_in_bus ();
    pcup_out_if pix_out_bus ();

    pixel_channel_unpack_pack i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_bus),
        .pix_out   (pix_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own view of the registers and the palette.
    pcup_pkg::cfg_t model_cfg;
    logic [23:0]    palette_model [pcup_pkg::PALETTE_DEPTH_DEF];

    // Entries written so far, so that paletted reads only hit written entries.
    bit          pal_written [pcup_pkg::PALETTE_DEPTH_DEF];
    logic [7:0]  written_list [$];

    pix_res_t      pending_results [$];
    known_answer_t known_answers [$];

    int          fail_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_requests;
    int unsigned cycle_count;

    // Effective pixel size; odd sizes behave as four bytes.
    function automatic logic [2:0] pixel_bytes();
        if (model_cfg.bpp >= 3'd1 && model_cfg.bpp <= 3'd4)
            return model_cfg.bpp;
        return 3'd4;
    endfunction

    function automatic logic [31:0] pixel_bits_mask();
        case (pixel_bytes())
            3'd1:    return 32'h0000_00FF;
            3'd2:    return 32'h0000_FFFF;
            3'd3:    return 32'h00FF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [4:0] chan_shift(input int c);
        return model_cfg.shifts[5*c +: 5];
    endfunction

    function automatic logic [3:0] chan_loss(input int c);
        return model_cfg.losses[4*c +: 4];
    endfunction

    function automatic logic [31:0] chan_mask(input int c);
        return (32'h0000_00FF >> chan_loss(c)) << chan_shift(c);
    endfunction

    // Works out the result word for one request under the current settings.
    function automatic pix_res_t convert_pixel(input pix_req_t w);
        pix_res_t    res;
        logic [31:0] pix;
        logic [31:0] alpha_mask;
        logic [31:0] field;
        logic [31:0] lane;
        logic [7:0]  chan_in [4];
        logic [7:0]  v [4];
        logic [23:0] entry;
        logic        paletted;
        res      = '0;
        v        = '{default: 8'h00};
        chan_in  = '{w.red, w.green, w.blue, w.alpha};
        paletted = (pixel_bytes() == 3'd1);
        case (w.req)
            pcup_pkg::REQ_RAW_UNPACK, pcup_pkg::REQ_SCALED_UNPACK:
            begin
                pix = w.pix & pixel_bits_mask();
                if (paletted)
                begin
                    entry = palette_model[pix[7:0]];
                    v[0]  = entry[23:16];
                    v[1]  = entry[15:8];
                    v[2]  = entry[7:0];
                    v[3]  = 8'hFF;
                end
                else
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        field = (pix & chan_mask(c)) >> chan_shift(c);
                        v[c]  = field[7:0];
                    end
                end
                // The colour key ignores alpha bits; paletted scaled reads skip it.
                if (!(paletted && w.req == pcup_pkg::REQ_SCALED_UNPACK) && model_cfg.ck_en)
                begin
                    alpha_mask = chan_mask(pcup_pkg::CH_ALPHA);
                    if ((model_cfg.ckey & ~alpha_mask) == (pix & ~alpha_mask))
                        v[3] = 8'h00;
                end
                if (w.req == pcup_pkg::REQ_SCALED_UNPACK && !paletted)
                begin
                    for (int c = 0; c < 3; c++)
                        v[c] = v[c] << chan_loss(c);
                    if (chan_loss(pcup_pkg::CH_ALPHA) == 4'd8)
                        v[3] = 8'hFF;
                    else
                        v[3] = v[3] << chan_loss(pcup_pkg::CH_ALPHA);
                end
                res.red   = v[0];
                res.green = v[1];
                res.blue  = v[2];
                res.alpha = v[3];
            end
            pcup_pkg::REQ_RAW_PACK, pcup_pkg::REQ_SCALED_PACK:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    lane = {24'd0, chan_in[c]};
                    if (w.req == pcup_pkg::REQ_SCALED_PACK)
                        lane = lane >> chan_loss(c);
                    res.pixel = res.pixel | (lane << chan_shift(c));
                end
                res.pixel = res.pixel & pixel_bits_mask();
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t row;
        row         = '{kind: ROW_REG, default: '0};
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = value;
        return row;
    endfunction

    // Channels are given as one word, red in the top byte and alpha in the bottom.
    function automatic stim_row_t word_row(input logic [2:0] req, input logic [31:0] pix,
                                           input logic [31:0] rgba, input logic [7:0] idx,
                                           input bit fixed, input logic [63:0] result);
        stim_row_t row;
        row            = '{kind: ROW_WORD, default: '0};
        row.kind       = ROW_WORD;
        row.word.req   = req;
        row.word.pix   = pix;
        row.word.red   = rgba[31:24];
        row.word.green = rgba[23:16];
        row.word.blue  = rgba[15:8];
        row.word.alpha = rgba[7:0];
        row.word.idx   = idx;
        row.fixed      = fixed;
        row.res        = result;
        return row;
    endfunction

    // Random request, mostly real conversions with a few unknown codes.
    function automatic pix_req_t random_word();
        pix_req_t w;
        int       pick;
        pick    = int'($urandom_range(99));
        w.pix   = $urandom;
        w.red   = 8'($urandom);
        w.green = 8'($urandom);
        w.blue  = 8'($urandom);
        w.alpha = 8'($urandom);
        w.idx   = 8'($urandom);
        if (pick < 30)
            w.req = pcup_pkg::REQ_RAW_UNPACK;
        else if (pick < 50)
            w.req = pcup_pkg::REQ_SCALED_UNPACK;
        else if (pick < 65)
            w.req = pcup_pkg::REQ_RAW_PACK;
        else if (pick < 80)
            w.req = pcup_pkg::REQ_SCALED_PACK;
        else if (pick < 92)
            w.req = pcup_pkg::REQ_PAL_WRITE;
        else
            w.req = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        if (w.req == pcup_pkg::REQ_RAW_UNPACK || w.req == pcup_pkg::REQ_SCALED_UNPACK)
        begin
            if (pixel_bytes() == 3'd1)
            begin
                // Only written palette entries may be read.
                if (written_list.size() == 0)
                    w.req = pcup_pkg::REQ_PAL_WRITE;
                else
                    w.pix[7:0] = written_list[$urandom_range(written_list.size() - 1)];
            end
            else if ($urandom_range(3) == 0)
            begin
                // Aim at the colour key with random alpha bits.
                w.pix = (model_cfg.ckey & ~chan_mask(pcup_pkg::CH_ALPHA)) |
                        (w.pix & chan_mask(pcup_pkg::CH_ALPHA));
            end
        end
        return w;
    endfunction

    // Drops valid, waits for every outstanding word, then lets the pipeline drain.
    task automatic settle();
        pix_in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pcup_pkg::CFG_BPP:     model_cfg.bpp    = value[2:0];
            pcup_pkg::CFG_SHIFTS:  model_cfg.shifts = value[19:0];
            pcup_pkg::CFG_LOSSES:  model_cfg.losses = value[15:0];
            pcup_pkg::CFG_CKEY:    model_cfg.ckey   = value;
            pcup_pkg::CFG_CKEY_EN: model_cfg.ck_en  = value[0];
            default:
            begin
            end
        endcase
    endtask

    // Offers one word, with a random gap first, and returns once it is taken.
    task automatic send_word(input pix_req_t w, input bit fixed, input pix_res_t res);
        known_answer_t k;
        while (int'($urandom_range(99)) < tx_idle_pct)
        begin
            pix_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        k.fixed = fixed;
        k.res   = res;
        known_answers.push_back(k);
        if (w.req == pcup_pkg::REQ_PAL_WRITE && !pal_written[w.idx])
        begin
            pal_written[w.idx] = 1'b1;
            written_list.push_back(w.idx);
        end
        pix_in_bus.valid         <= 1'b1;
        pix_in_bus.req_type      <= w.req;
        pix_in_bus.pixel_value   <= w.pix;
        pix_in_bus.in_red        <= w.red;
        pix_in_bus.in_green      <= w.green;
        pix_in_bus.in_blue       <= w.blue;
        pix_in_bus.in_alpha      <= w.alpha;
        pix_in_bus.palette_index <= w.idx;
        @(posedge clk);
        while (pix_in_bus.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Writes every register for one random segment, extremes in the first three.
    task automatic configure_segment(input int seg);
        logic [2:0]  bpp;
        logic [19:0] shifts;
        logic [15:0] losses;
        logic [31:0] ckey;
        logic        ck_en;
        case (seg)
            0:       bpp = 3'd4;
            1:       bpp = 3'd1;
            2:       bpp = 3'd3;
            3:       bpp = 3'd2;
            4:       bpp = 3'd0;
            5:       bpp = 3'd1;
            6:       bpp = 3'd5;
            default: bpp = 3'd7;
        endcase
        write_register(pcup_pkg::CFG_BPP, {29'd0, bpp});
        case (seg)
            0:
            begin
                shifts = '0;
                losses = '0;
                ckey   = '0;
                ck_en  = 1'b1;
            end
            1:
            begin
                shifts = '1;
                losses = '1;
                ckey   = '1;
                ck_en  = 1'b1;
            end
            default:
            begin
                shifts = 20'($urandom);
                for (int c = 0; c < 4; c++)
                    losses[4*c +: 4] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                                : 4'($urandom_range(8));
                if (seg == 2)
                    losses = 16'h8888;
                ckey  = $urandom;
                // A key within the pixel width can actually be matched.
                if ($urandom_range(1) == 0)
                    ckey = ckey & pixel_bits_mask();
                ck_en = 1'($urandom_range(1));
            end
        endcase
        write_register(pcup_pkg::CFG_SHIFTS, {12'd0, shifts});
        write_register(pcup_pkg::CFG_LOSSES, {16'd0, losses});
        write_register(pcup_pkg::CFG_CKEY, ckey);
        write_register(pcup_pkg::CFG_CKEY_EN, {31'd0, ck_en});
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is asked for.
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pix_out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out_bus.ready <= 1'b0;
            end
            else
                pix_out_bus.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // Each accepted request gets its expected word, typed in or predicted.
    always @(posedge clk)
    begin : accept_request
        pix_req_t      w;
        pix_res_t      res;
        known_answer_t k;
        if (rst_n && pix_in_bus.valid && pix_in_bus.ready)
        begin
            w.req   = pix_in_bus.req_type;
            w.pix   = pix_in_bus.pixel_value;
            w.red   = pix_in_bus.in_red;
            w.green = pix_in_bus.in_green;
            w.blue  = pix_in_bus.in_blue;
            w.alpha = pix_in_bus.in_alpha;
            w.idx   = pix_in_bus.palette_index;
            res     = convert_pixel(w);
            if (known_answers.size() != 0)
            begin
                k = known_answers.pop_front();
                if (k.fixed)
                    res = k.res;
            end
            if (w.req == pcup_pkg::REQ_PAL_WRITE)
                palette_model[w.idx] = {w.red, w.green, w.blue};
            pending_results.push_back(res);
        end
    end

    // Each result word is compared field by field with the oldest expected word.
    always @(posedge clk)
    begin : check_result
        pix_res_t got;
        pix_res_t want;
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            got.pixel = pix_out_bus.out_pixel;
            got.red   = pix_out_bus.out_red;
            got.green = pix_out_bus.out_green;
            got.blue  = pix_out_bus.out_blue;
            got.alpha = pix_out_bus.out_alpha;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected word: expected none, got %h rgba %h%h%h%h",
                             $time, got.pixel, got.red, got.green, got.blue, got.alpha);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pixel !== want.pixel || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.alpha !== want.alpha)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t: mismatch: expected %h/%h%h%h%h, got %h/%h%h%h%h",
                                 $time, want.pixel, want.red, want.green, want.blue,
                                 want.alpha, got.pixel, got.red, got.green, got.blue,
                                 got.alpha);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t directed_rows [$];
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= '0;
        cfg_data                 <= '0;
        pix_in_bus.valid         <= 1'b0;
        pix_in_bus.req_type      <= '0;
        pix_in_bus.pixel_value   <= '0;
        pix_in_bus.in_red        <= '0;
        pix_in_bus.in_green      <= '0;
        pix_in_bus.in_blue       <= '0;
        pix_in_bus.in_alpha      <= '0;
        pix_in_bus.palette_index <= '0;
        fail_count    = 0;
        hold_requests = 0;
        tx_idle_pct   = 35;
        rx_idle_pct   = 63;
        model_cfg.bpp    = 3'd4;
        model_cfg.shifts = 20'd8728;
        model_cfg.losses = '0;
        model_cfg.ckey   = '0;
        model_cfg.ck_en  = 1'b0;

        // Register defaults: red at 24, green at 16, blue at 8, alpha at 0, no loss.
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'h0000_0000, 32'h0,
                                         8'h00, 1, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hFFFF_FFFF, 32'h0,
                                         8'h00, 1, {32'h0, 32'hFFFF_FFFF}));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'h1234_5678, 32'h0,
                                         8'h00, 1, {32'h0, 32'h1234_5678}));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_UNPACK, 32'h8765_4321, 32'h0,
                                         8'h00, 1, {32'h0, 32'h8765_4321}));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_PACK, 32'h0, 32'hFFFF_FFFF,
                                         8'h00, 1, {32'hFFFF_FFFF, 32'h0}));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_PACK, 32'h0, 32'h0,
                                         8'h00, 1, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_PACK, 32'hFFFF_FFFF,
                                         32'h1234_5678, 8'h00, 1, {32'h1234_5678, 32'h0}));
        // Palette writes at both ends of the store; their words are all zero.
        directed_rows.push_back(word_row(pcup_pkg::REQ_PAL_WRITE, 32'h0, 32'h1122_33FF,
                                         8'h00, 1, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_PAL_WRITE, 32'hFFFF_FFFF,
                                         32'hFFFF_FF00, 8'hFF, 1, 64'h0));
        // Unknown requests change nothing and give zero.
        directed_rows.push_back(word_row(REQ_BAD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1,
                                         64'h0));
        directed_rows.push_back(word_row(REQ_BAD_MID, 32'h1234_5678, 32'h1234_5678, 8'h12,
                                         1, 64'h0));
        directed_rows.push_back(word_row(REQ_BAD_HI, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h00, 1,
                                         64'h0));
        // Alpha and blue lose eight bits, green four, red three.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_LOSSES, 32'h0000_8843));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_UNPACK, 32'hFFFF_FFFF, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hFFFF_FFFF, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_PACK, 32'h0, 32'hFFFF_FFFF,
                                         8'h00, 0, 64'h0));
        // Losses above eight empty the masks.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_LOSSES, 32'h0000_F9F9));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hFFFF_FFFF, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_PACK, 32'h0, 32'hFFFF_FFFF,
                                         8'h00, 0, 64'h0));
        // Colour key: a match on the colour bits clears alpha, a near miss does not.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_LOSSES, 32'h0));
        directed_rows.push_back(reg_row(pcup_pkg::CFG_CKEY, 32'h1122_3300));
        directed_rows.push_back(reg_row(pcup_pkg::CFG_CKEY_EN, 32'h1));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'h1122_33AB, 32'h0,
                                         8'h00, 1, {32'h0, 32'h1122_3300}));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'h1122_34AB, 32'h0,
                                         8'h00, 1, {32'h0, 32'h1122_34AB}));
        // Two-byte pixels: upper bits are dropped on both paths.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_BPP, 32'd2));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hFFFF_1234, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_PACK, 32'h0, 32'hFFFF_FFFF,
                                         8'h00, 1, {32'h0000_FFFF, 32'h0}));
        // Paletted reads: raw with a colour key hit, then scaled which skips the key.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_CKEY, 32'h0));
        directed_rows.push_back(reg_row(pcup_pkg::CFG_BPP, 32'd1));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hABCD_EF00, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_SCALED_UNPACK, 32'h0000_00FF, 32'h0,
                                         8'h00, 0, 64'h0));
        // Odd pixel sizes act as four bytes.
        directed_rows.push_back(reg_row(pcup_pkg::CFG_BPP, 32'd6));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_UNPACK, 32'hFFFF_FFFF, 32'h0,
                                         8'h00, 0, 64'h0));
        directed_rows.push_back(reg_row(pcup_pkg::CFG_BPP, 32'd0));
        directed_rows.push_back(word_row(pcup_pkg::REQ_RAW_PACK, 32'h0, 32'h89AB_CDEF,
                                         8'h00, 0, 64'h0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].res);
        end

        // Random segments, each under fresh settings; the idling pattern changes twice.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            if (seg == 3)
            begin
                tx_idle_pct = 63;
                rx_idle_pct = 35;
            end
            if (seg == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            configure_segment(seg);
            // Long receiver hold-off while the sender keeps pushing.
            if (seg == 6)
                hold_requests++;
            repeat (SEGMENT_WORDS) send_word(random_word(), 1'b0, '0);
        end

        settle();
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
